[hdl/sst_pkg.sv]
// Shared types, codes and default sizes for the scoped symbol table.
`timescale 1ns / 1ps
package sst_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_STORE_SLOTS = 64;
  localparam int DEF_MAX_SCOPES  = 16;
  localparam int DEF_ENTRY_BITS  = 32;

  // Fixed field widths of the request and result words.
  localparam int KEY_BITS   = 64;
  localparam int FIELD_BITS = 32;
  localparam int DEPTH_BITS = 5;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_PUSH   = 2'd2,
    REQ_POP    = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_SCOPE   = 3'd1,
    ST_STACK_FULL = 3'd2,
    ST_STORE_FULL = 3'd3,
    ST_RESERVED   = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_RESPOND
  } ctrl_state_t;

  // Request word.
  typedef struct packed {
    req_t                  req_type;
    logic [FIELD_BITS-1:0] key_index;
    logic [FIELD_BITS-1:0] key_generation;
    logic [FIELD_BITS-1:0] entry_value;
  } request_t;

  // Result word.
  typedef struct packed {
    logic                  found;
    logic [FIELD_BITS-1:0] entry_out;
    status_t               status;
    logic [DEPTH_BITS-1:0] scope_depth;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear_wr;
    logic issue;
    logic commit;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_addr;
    logic quick;
    req_t req_type;
  } dp_stat_t;

endpackage

[hdl/sst_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/sst_ctrl.sv]
// Controller state machine that sequences clearing, scans, commits and results.
`timescale 1ns / 1ps
module sst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  sst_pkg::dp_stat_t    stat,
  output sst_pkg::ctrl_cmd_t   cmd,
  output logic                 busy
);

  sst_pkg::ctrl_state_t state;
  sst_pkg::ctrl_state_t state_next;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sst_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      sst_pkg::S_CLEAR: begin
        if (stat.last_addr) state_next = sst_pkg::S_IDLE;
      end
      sst_pkg::S_IDLE: begin
        if (start) state_next = sst_pkg::S_CHECK;
      end
      sst_pkg::S_CHECK: begin
        state_next = stat.quick ? sst_pkg::S_RESPOND : sst_pkg::S_SCAN;
      end
      sst_pkg::S_SCAN: begin
        if (stat.last_addr) state_next = sst_pkg::S_DRAIN;
      end
      sst_pkg::S_DRAIN: begin
        state_next = (stat.req_type == sst_pkg::REQ_INSERT) ? sst_pkg::S_COMMIT
                                                            : sst_pkg::S_RESPOND;
      end
      sst_pkg::S_COMMIT: begin
        state_next = sst_pkg::S_RESPOND;
      end
      sst_pkg::S_RESPOND: begin
        state_next = sst_pkg::S_IDLE;
      end
      default: begin
        state_next = sst_pkg::S_CLEAR;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd.load     = (state == sst_pkg::S_IDLE) && start;
    cmd.clear_wr = (state == sst_pkg::S_CLEAR);
    cmd.issue    = (state == sst_pkg::S_SCAN);
    cmd.commit   = (state == sst_pkg::S_COMMIT);
    cmd.finish   = (state == sst_pkg::S_RESPOND);
    busy         = (state != sst_pkg::S_IDLE);
  end

endmodule

[hdl/sst_datapath.sv]
// Datapath: request register, slot store, scan address, match tracking and result word.
`timescale 1ns / 1ps
module sst_datapath #(
  parameter int STORE_SLOTS = sst_pkg::DEF_STORE_SLOTS,
  parameter int MAX_SCOPES  = sst_pkg::DEF_MAX_SCOPES,
  parameter int ENTRY_BITS  = sst_pkg::DEF_ENTRY_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sst_pkg::ctrl_cmd_t   cmd,
  output sst_pkg::dp_stat_t    stat,
  input  sst_pkg::request_t    request,
  output logic                 done,
  output sst_pkg::result_t     result
);

  localparam int ADDR_W = $clog2(STORE_SLOTS);
  localparam int TAG_W  = (MAX_SCOPES > 1) ? $clog2(MAX_SCOPES) : 1;
  localparam int OPEN_W = $clog2(MAX_SCOPES + 1);
  localparam int VAL_W  = (ENTRY_BITS < sst_pkg::FIELD_BITS) ? ENTRY_BITS
                                                             : sst_pkg::FIELD_BITS;
  localparam int WORD_W = 1 + TAG_W + sst_pkg::KEY_BITS + VAL_W;

  sst_pkg::request_t            req;
  logic [ADDR_W-1:0]            cnt;
  logic                         rd_valid;
  logic [ADDR_W-1:0]            rd_addr;
  logic [OPEN_W-1:0]            open_scopes;
  logic [OPEN_W-1:0]            open_next;
  logic                         hit;
  logic [TAG_W-1:0]             best_tag;
  logic [VAL_W-1:0]             best_val;
  logic                         match;
  logic [ADDR_W-1:0]            match_slot;
  logic                         have_free;
  logic [ADDR_W-1:0]            free_slot;

  logic [sst_pkg::KEY_BITS-1:0] key;
  logic [VAL_W-1:0]             val;
  logic [TAG_W-1:0]             top;
  logic                         reserved;
  logic                         no_scope;
  logic                         stack_full;
  logic                         is_insert;
  logic                         is_lookup;
  logic                         is_push;
  logic                         is_pop;
  sst_pkg::status_t             res_status;

  logic [WORD_W-1:0]            rd_data;
  logic                         rd_vld;
  logic [TAG_W-1:0]             rd_tag;
  logic [sst_pkg::KEY_BITS-1:0] rd_key;
  logic [VAL_W-1:0]             rd_val;
  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [WORD_W-1:0]            wr_data;

  // Decode of the held request.
  assign key        = {req.key_generation, req.key_index};
  assign val        = req.entry_value[VAL_W-1:0];
  assign top        = TAG_W'(open_scopes - OPEN_W'(1));
  assign reserved   = &key;
  assign no_scope   = (open_scopes == '0);
  assign stack_full = (open_scopes == OPEN_W'(MAX_SCOPES));
  assign is_insert  = (req.req_type == sst_pkg::REQ_INSERT);
  assign is_lookup  = (req.req_type == sst_pkg::REQ_LOOKUP);
  assign is_push    = (req.req_type == sst_pkg::REQ_PUSH);
  assign is_pop     = (req.req_type == sst_pkg::REQ_POP);

  // Status toward the controller.
  assign stat.last_addr = (cnt == ADDR_W'(STORE_SLOTS - 1));
  assign stat.quick     = is_push || no_scope || (!is_pop && reserved);
  assign stat.req_type  = req.req_type;

  // Fields of the slot word that comes back from the store.
  assign rd_vld = rd_data[WORD_W-1];
  assign rd_tag = rd_data[WORD_W-2 -: TAG_W];
  assign rd_key = rd_data[VAL_W +: sst_pkg::KEY_BITS];
  assign rd_val = rd_data[VAL_W-1:0];

  // Write port: clearing pass, insert commit, or invalidation during a pop scan.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_data = {1'b0, rd_data[WORD_W-2:0]};
    priority if (cmd.clear_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt;
      wr_data = '0;
    end else if (cmd.commit) begin
      wr_en   = match || have_free;
      wr_addr = match ? match_slot : free_slot;
      wr_data = {1'b1, top, key, val};
    end else if (rd_valid && is_pop && rd_vld && (rd_tag == top)) begin
      wr_en = 1'b1;
    end else begin
      wr_en = 1'b0;
    end
  end

  sst_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (cnt),
    .rdata (rd_data)
  );

  // Request register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request;
    end
  end

  // Slot address counter and read pipeline tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.clear_wr || cmd.issue) begin
        cnt <= cnt + ADDR_W'(1);
      end
      rd_valid <= cmd.issue;
    end
    rd_addr <= cnt;
  end

  // Match tracking over the scan: innermost hit for lookup, own-scope
  // match and first free slot for insert.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit       <= 1'b0;
      match     <= 1'b0;
      have_free <= 1'b0;
    end else if (cmd.load) begin
      hit       <= 1'b0;
      match     <= 1'b0;
      have_free <= 1'b0;
    end else if (rd_valid) begin
      if (is_lookup && rd_vld && (rd_key == key) && (!hit || (rd_tag > best_tag))) begin
        hit      <= 1'b1;
        best_tag <= rd_tag;
        best_val <= rd_val;
      end
      if (is_insert && rd_vld && (rd_tag == top) && (rd_key == key) && !match) begin
        match      <= 1'b1;
        match_slot <= rd_addr;
      end
      if (is_insert && !rd_vld && !have_free) begin
        have_free <= 1'b1;
        free_slot <= rd_addr;
      end
    end
  end

  // Result status; the order of the checks sets which one wins.
  always_comb begin
    priority if (is_push) begin
      res_status = stack_full ? sst_pkg::ST_STACK_FULL : sst_pkg::ST_OK;
    end else if (no_scope) begin
      res_status = sst_pkg::ST_NO_SCOPE;
    end else if (is_pop) begin
      res_status = sst_pkg::ST_OK;
    end else if (reserved) begin
      res_status = sst_pkg::ST_RESERVED;
    end else if (is_insert && !match && !have_free) begin
      res_status = sst_pkg::ST_STORE_FULL;
    end else begin
      res_status = sst_pkg::ST_OK;
    end
  end

  // Scope depth after this request.
  always_comb begin
    open_next = open_scopes;
    if (is_push && !stack_full) begin
      open_next = open_scopes + OPEN_W'(1);
    end else if (is_pop && !no_scope) begin
      open_next = open_scopes - OPEN_W'(1);
    end
  end

  // Scope counter and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      open_scopes <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        open_scopes <= open_next;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.found       <= hit;
      result.entry_out   <= hit ? sst_pkg::FIELD_BITS'(best_val) : '0;
      result.status      <= res_status;
      result.scope_depth <= sst_pkg::DEPTH_BITS'(open_next);
    end
  end

endmodule

[hdl/scoped_symbol_table.sv]
// Top level of the scoped symbol table: controller and datapath.
// Push, and requests rejected before any scan, go from the check straight to respond.
// Lookup and pop scan every slot, one slot per cycle through the single read port of
// the slot store, then drain; insert adds a commit step before respond.
// The result word is flagged by done for one cycle, registered after respond; no stall.
// After reset, busy stays high while every slot is invalidated.
`timescale 1ns / 1ps
module scoped_symbol_table #(
  parameter int STORE_SLOTS = sst_pkg::DEF_STORE_SLOTS,
  parameter int MAX_SCOPES  = sst_pkg::DEF_MAX_SCOPES,
  parameter int ENTRY_BITS  = sst_pkg::DEF_ENTRY_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sst_pkg::request_t   request,
  output logic                done,
  output sst_pkg::result_t    result
);

  sst_pkg::ctrl_cmd_t cmd;
  sst_pkg::dp_stat_t  stat;

  // Sequencer.
  sst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Store and result logic.
  sst_datapath #(
    .STORE_SLOTS (STORE_SLOTS),
    .MAX_SCOPES  (MAX_SCOPES),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .request (request),
    .done    (done),
    .result  (result)
  );

endmodule

[tb/scoped_symbol_table_test.sv]
// Self-checking testbench for the scoped symbol table: directed and random request words.
`timescale 1ns / 1ps
module scoped_symbol_table_test;
  import sst_pkg::*;

  localparam int SLOTS      = DEF_STORE_SLOTS;
  localparam int SCOPES     = DEF_MAX_SCOPES;
  localparam int VALUE_BITS = DEF_ENTRY_BITS;
  localparam logic [KEY_BITS-1:0] RESERVED_KEY = '1;

  // Mirror of the scoped store plus the queue of results still owed by the block.
  class symbol_table_scoreboard;
    logic [KEY_BITS-1:0]   slot_key   [SLOTS];
    logic [FIELD_BITS-1:0] slot_value [SLOTS];
    int unsigned           slot_level [SLOTS];
    bit                    slot_live  [SLOTS];
    int unsigned           open_depth;
    result_t               owed_results[$];
    int unsigned mismatches, checked, hits, store_full, stack_full, reserved, no_scope;

    function new();
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      open_depth = 0;
      mismatches = 0;
      checked    = 0;
      hits       = 0;
      store_full = 0;
      stack_full = 0;
      reserved   = 0;
      no_scope   = 0;
    endfunction

    // Apply one request word to the mirror and return the result it must produce.
    function automatic result_t apply_request(request_t w);
      result_t               r;
      logic [KEY_BITS-1:0]   key;
      logic [FIELD_BITS-1:0] value;
      int unsigned           top;
      int                    hit_slot;
      int                    free_slot;
      r         = '0;
      key       = {w.key_generation, w.key_index};
      value     = w.entry_value & FIELD_BITS'((64'd2 << (VALUE_BITS - 1)) - 1);
      top       = open_depth - 1;
      hit_slot  = -1;
      free_slot = -1;
      r.status  = ST_OK;
      if (w.req_type == REQ_PUSH) begin
        if (open_depth >= SCOPES) r.status = ST_STACK_FULL;
        else open_depth++;
      end else if (open_depth == 0) begin
        // The missing scope wins over every other check but push.
        r.status = ST_NO_SCOPE;
      end else if (w.req_type == REQ_POP) begin
        foreach (slot_live[i])
          if (slot_live[i] && slot_level[i] == top) slot_live[i] = 1'b0;
        open_depth = top;
      end else if (key == RESERVED_KEY) begin
        r.status = ST_RESERVED;
      end else if (w.req_type == REQ_INSERT) begin
        // Overwrite within the innermost scope, else take the lowest free slot.
        foreach (slot_live[i]) begin
          if (slot_live[i]) begin
            if (hit_slot < 0 && slot_level[i] == top && slot_key[i] == key) hit_slot = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit_slot >= 0) begin
          slot_value[hit_slot] = value;
        end else if (free_slot < 0) begin
          r.status = ST_STORE_FULL;
        end else begin
          slot_live[free_slot]  = 1'b1;
          slot_key[free_slot]   = key;
          slot_value[free_slot] = value;
          slot_level[free_slot] = top;
        end
      end else begin
        // Lookup: the deepest scope holding the key wins.
        foreach (slot_live[i])
          if (slot_live[i] && slot_key[i] == key &&
              (hit_slot < 0 || slot_level[i] > slot_level[hit_slot])) hit_slot = i;
        if (hit_slot >= 0) begin
          r.found     = 1'b1;
          r.entry_out = slot_value[hit_slot];
        end
      end
      r.scope_depth = DEPTH_BITS'(open_depth);
      return r;
    endfunction

    // Note an accepted request word and queue the result it owes.
    function void note_request(request_t w);
      result_t want;
      want = apply_request(w);
      if (want.found) hits++;
      case (want.status)
        ST_NO_SCOPE:   no_scope++;
        ST_STACK_FULL: stack_full++;
        ST_STORE_FULL: store_full++;
        ST_RESERVED:   reserved++;
        default: ;
      endcase
      owed_results.push_back(want);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t ns: mismatch on %s: got %h, wanted %h", $time, what, got, want);
      mismatches++;
    endtask

    // Compare one result word against the oldest owed result.
    task check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result word", 64'(got), 64'd0);
        return;
      end
      want = owed_results.pop_front();
      checked++;
      if (got.found !== want.found) report_mismatch("found", 64'(got.found), 64'(want.found));
      if (got.entry_out !== want.entry_out)
        report_mismatch("entry_out", 64'(got.entry_out), 64'(want.entry_out));
      if (got.status !== want.status) report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.scope_depth !== want.scope_depth)
        report_mismatch("scope_depth", 64'(got.scope_depth), 64'(want.scope_depth));
    endtask

    // Anything still owed at the end never came out of the block.
    task flush_owed();
      result_t want;
      while (owed_results.size() != 0) begin
        want = owed_results.pop_front();
        report_mismatch("missing result word", 64'd0, 64'(want));
      end
    endtask
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  logic     done;
  request_t request;
  result_t  result;
  int       idle_pct;
  logic [FIELD_BITS-1:0] index_pool[32];
  logic [FIELD_BITS-1:0] gen_pool[4];
  symbol_table_scoreboard sb = new();

  scoped_symbol_table u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // 50 MHz clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Results show for one cycle only, so every strobe is checked at the edge ending it.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // Offer one word, with random idle cycles first, and hold it until accepted.
  task automatic send_word(request_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= w;
    do @(posedge clk); while (busy);
    sb.note_request(w);
  endtask

  task automatic send_fields(req_t op, logic [31:0] idx, logic [31:0] gen, logic [31:0] value);
    request_t w;
    w.req_type       = op;
    w.key_index      = idx;
    w.key_generation = gen;
    w.entry_value    = value;
    send_word(w);
  endtask

  // Random word drawn from a small key pool so that lookups hit and scopes fill up.
  // Mix 0 is balanced, mix 1 grows the stack and fills the store, mix 2 churns scopes.
  function automatic request_t make_word(int mix);
    request_t w;
    int       roll;
    int       insert_pct;
    int       lookup_pct;
    int       push_pct;
    w.key_index      = index_pool[$urandom_range(31)];
    w.key_generation = gen_pool[$urandom_range(3)];
    w.entry_value    = $urandom;
    roll             = $urandom_range(99);
    case (mix)
      0: begin
        insert_pct = 40; lookup_pct = 35; push_pct = 13;
      end
      1: begin
        insert_pct = 55; lookup_pct = 15; push_pct = 25;
      end
      default: begin
        insert_pct = 30; lookup_pct = 40; push_pct = 12;
      end
    endcase
    if ($urandom_range(99) < 8) begin
      // Noise: any request with a fully random key, sometimes the reserved one.
      w.req_type       = req_t'(2'($urandom_range(3)));
      w.key_index      = $urandom;
      w.key_generation = $urandom;
      if ($urandom_range(3) == 0) {w.key_generation, w.key_index} = RESERVED_KEY;
    end else if (roll < insert_pct) begin
      w.req_type = REQ_INSERT;
    end else if (roll < insert_pct + lookup_pct) begin
      w.req_type = REQ_LOOKUP;
    end else if (roll < insert_pct + lookup_pct + push_pct) begin
      w.req_type = REQ_PUSH;
    end else begin
      w.req_type = REQ_POP;
    end
    return w;
  endfunction

  initial begin
    int drain_cycles;
    rst      = 1'b1;
    start    = 1'b0;
    request  = '0;
    idle_pct = 0;
    foreach (index_pool[i]) index_pool[i] = $urandom;
    index_pool[0] = '0;
    index_pool[1] = '1;
    gen_pool[0]   = '0;
    gen_pool[1]   = '1;
    gen_pool[2]   = $urandom;
    gen_pool[3]   = $urandom;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Requests with no scope open, the reserved key among them.
    send_fields(REQ_LOOKUP, 32'h1, 32'h2, 32'h0);
    send_fields(REQ_INSERT, 32'h1, 32'h2, 32'hDEAD_BEEF);
    send_fields(REQ_POP,    32'h0, 32'h0, 32'h0);
    send_fields(REQ_INSERT, '1, '1, '1);
    // One scope: reserved key, extreme keys and values, hit, miss, overwrite.
    send_fields(REQ_PUSH,   '1, '1, '1);
    send_fields(REQ_INSERT, '1, '1, 32'h1234_5678);
    send_fields(REQ_LOOKUP, '1, '1, 32'h0);
    send_fields(REQ_INSERT, 32'h0, 32'h0, '1);
    send_fields(REQ_INSERT, '1, 32'h0, 32'h0);
    send_fields(REQ_INSERT, 32'h0, '1, 32'h1234_5678);
    send_fields(REQ_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_fields(REQ_LOOKUP, '1, 32'hFFFF_FFFE, 32'h0);
    send_fields(REQ_INSERT, 32'h0, 32'h0, 32'hA5A5_A5A5);
    // A nested scope shadows the outer entry until it is popped.
    send_fields(REQ_PUSH,   32'h0, 32'h0, 32'h0);
    send_fields(REQ_INSERT, 32'h0, 32'h0, 32'h5A5A_5A5A);
    send_fields(REQ_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_fields(REQ_LOOKUP, 32'h0, '1, 32'h0);
    send_fields(REQ_LOOKUP, '1, 32'h0, 32'h0);
    send_fields(REQ_POP,    32'h0, 32'h0, 32'h0);
    send_fields(REQ_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_fields(REQ_POP,    32'h0, 32'h0, 32'h0);
    send_fields(REQ_LOOKUP, 32'h0, 32'h0, 32'h0);

    // Random phases; the receiver cannot stall, so only the sender idles, in some phases.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0:       idle_pct = 0;
        1:       idle_pct = 72;
        2:       idle_pct = 0;
        default: idle_pct = 34;
      endcase
      repeat (125) send_word(make_word(phase % 3));
    end
    start <= 1'b0;

    // Let the last results out, then idle before flushing what is still owed.
    drain_cycles = 0;
    while (sb.owed_results.size() != 0 && drain_cycles < 4 * SLOTS + 100) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (2 * SLOTS + 10) @(posedge clk);
    sb.flush_owed();

    $display("Checked %0d results: %0d lookup hits, %0d reserved-key, %0d no-scope answers.",
             sb.checked, sb.hits, sb.reserved, sb.no_scope);
    $display("Store-full answers: %0d, scope-stack-full answers: %0d, mismatches: %0d.",
             sb.store_full, sb.stack_full, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS scoped_symbol_table");
    end else begin
      $display("FAIL scoped_symbol_table");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #(20_000_000);
    $display("Watchdog expired before the run completed.");
    $display("FAIL scoped_symbol_table");
    $finish;
  end

endmodule

[sim.f]
hdl/sst_pkg.sv
hdl/sst_ram.sv
hdl/sst_ctrl.sv
hdl/sst_datapath.sv
hdl/scoped_symbol_table.sv
tb/scoped_symbol_table_test.sv
